@@ design/vertical_comb_detect_core_macros.svh @@
// Assertion macros used by the checker module of the comb detector.
// No dependencies; included by bare file name.
`ifndef VERTICAL_COMB_DETECT_CORE_MACROS_SVH
`define VERTICAL_COMB_DETECT_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define VCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define VCD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/vcd_pkg.sv @@
// Package for the vertical comb detector: sizes, register indexes, the
// raster position struct and the five-tap comb metric function. No dependencies.
package vcd_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int LINES_KEPT  = 4;
   localparam int PIX_BITS    = 8;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = 12;
   localparam int WORD_BITS   = LINES_KEPT * PIX_BITS;
   localparam int WIDTH_BITS  = 12;
   localparam int HEIGHT_BITS = 13;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 13;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT = CSR_IDX_BITS'(1);

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(1920);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(1080);

   localparam logic [ROW_BITS-1:0] FIRST_INTERIOR_ROW = ROW_BITS'(4);

   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic                interior;
      logic                row_end;
      logic                frame_end;
   } raster_type;

   // |a + 4c + e - 3(b + d)| >> 2, clamped to 255
   function automatic logic [PIX_BITS-1:0] comb_metric(
      input logic [PIX_BITS-1:0] a,
      input logic [PIX_BITS-1:0] b,
      input logic [PIX_BITS-1:0] c,
      input logic [PIX_BITS-1:0] d,
      input logic [PIX_BITS-1:0] e
   );
      logic [10:0] pos_sum;
      logic [8:0]  bd_sum;
      logic [10:0] neg_sum;
      logic [10:0] diff;
      logic [8:0]  quarter;
      pos_sum = {3'b000, a} + {1'b0, c, 2'b00} + {3'b000, e};
      bd_sum  = {1'b0, b} + {1'b0, d};
      neg_sum = {2'b00, bd_sum} + {1'b0, bd_sum, 1'b0};
      diff    = (pos_sum >= neg_sum) ? (pos_sum - neg_sum) : (neg_sum - pos_sum);
      quarter = diff[10:2];
      return quarter[8] ? {PIX_BITS{1'b1}} : quarter[PIX_BITS-1:0];
   endfunction

endpackage

@@ design/vertical_comb_detect_core.sv @@
// Vertical five-tap comb detector, top level.
// Depends on vcd_pkg, vcd_raster and vcd_ram.
//
// Usage:
//   req_ channel carries luma pixels in raster order; rsp_ channel returns one
//   result per pixel: the clamped comb metric of the pixel two rows up, the
//   interior flag (full five-row window) and row/frame end markers.
//   A request is taken when req_valid is high and req_stall low; likewise
//   a result on rsp_valid / rsp_stall.
//   csr_ writes set frame_width (index 0) and frame_height (index 1); write
//   them only while no request is in flight.
// Pipeline: RAM read stage, then result register.
// Throughput: one pixel per cycle unless req_stall is high; the line buffer is a
//   single 2048 x 32 RAM for all four rows of a column, read/written once per pixel.
// Reset: counters clear and the line buffer is zeroed by a clearing pass over
//   all 2048 columns, one column per cycle, with req_stall held high meanwhile.
// Stall: a stalled result holds; one more pixel is held in the read stage,
//   then req_stall rises until the result is taken.
module vertical_comb_detect_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [vcd_pkg::PIX_BITS-1:0]      req_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [vcd_pkg::PIX_BITS-1:0]      rsp_comb_value,
   output logic                              rsp_interior,
   output logic                              rsp_row_end,
   output logic                              rsp_frame_end,
   input  logic                              csr_write,
   input  logic [vcd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [vcd_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import vcd_pkg::*;

   logic [WIDTH_BITS-1:0]  width_ff;
   logic [HEIGHT_BITS-1:0] height_ff;

   logic                clr_busy_ff;
   logic [COL_BITS-1:0] clr_addr_ff;

   logic accept;
   logic advance_a;
   raster_type pos;

   logic                valid_a_ff;
   logic [PIX_BITS-1:0] pix_a_ff;
   raster_type          pos_a_ff;

   logic                 byp_ff;
   logic [WORD_BITS-1:0] byp_word_ff;
   logic                 hazard;

   logic [WORD_BITS-1:0] ram_rd_data;
   logic [WORD_BITS-1:0] taps;
   logic [WORD_BITS-1:0] wr_word;
   logic                 ram_wr_en;
   logic [COL_BITS-1:0]  ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;

   logic                rsp_valid_ff;
   logic [PIX_BITS-1:0] rsp_comb_ff;
   logic                rsp_interior_ff;
   logic                rsp_row_end_ff;
   logic                rsp_frame_end_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            width_ff <= csr_data[WIDTH_BITS-1:0];
         end
         if (csr_index == CSR_FRAME_HEIGHT) begin
            height_ff <= csr_data[HEIGHT_BITS-1:0];
         end
      end
   end

   // line buffer clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + COL_BITS'(1);
         if (clr_addr_ff == COL_BITS'(MAX_WIDTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   assign advance_a = valid_a_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clr_busy_ff || (valid_a_ff && rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   vcd_raster u_raster (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .pos        (pos)
   );

   // column word: [31:24] four rows up ... [7:0] one row up
   assign taps    = byp_ff ? byp_word_ff : ram_rd_data;
   assign wr_word = {taps[WORD_BITS-PIX_BITS-1:0], pix_a_ff};

   // same column read while it is written (one-pixel rows): forward the write
   assign hazard = advance_a && (pos.col == pos_a_ff.col);

   assign ram_wr_en   = clr_busy_ff || advance_a;
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : pos_a_ff.col;
   assign ram_wr_data = clr_busy_ff ? '0 : wr_word;

   vcd_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (pos.col),
      .rd_data (ram_rd_data)
   );

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (accept) begin
         valid_a_ff <= 1'b1;
      end else if (advance_a) begin
         valid_a_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_a_ff    <= req_pixel;
         pos_a_ff    <= pos;
         byp_word_ff <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (accept) begin
         byp_ff <= hazard;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance_a) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_a) begin
         rsp_comb_ff      <= pos_a_ff.interior ?
                             comb_metric(taps[31:24], taps[23:16], taps[15:8], taps[7:0],
                                         pix_a_ff) : '0;
         rsp_interior_ff  <= pos_a_ff.interior;
         rsp_row_end_ff   <= pos_a_ff.row_end;
         rsp_frame_end_ff <= pos_a_ff.frame_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_comb_value = rsp_comb_ff;
   assign rsp_interior   = rsp_interior_ff;
   assign rsp_row_end    = rsp_row_end_ff;
   assign rsp_frame_end  = rsp_frame_end_ff;

endmodule

@@ design/vcd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vcd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/vcd_raster.sv @@
// Column and row counters of the comb detector; gives the position and
// row/frame flags of the next request. Depends on vcd_pkg.
module vcd_raster (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [vcd_pkg::WIDTH_BITS-1:0]  cfg_width,
   input  logic [vcd_pkg::HEIGHT_BITS-1:0] cfg_height,
   output vcd_pkg::raster_type             pos
);
   import vcd_pkg::*;

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] last_col;
   logic [ROW_BITS-1:0] last_row;

   // out-of-range sizes clamp to 1 .. limit
   always_comb begin
      priority if (cfg_width == '0) begin
         last_col = '0;
      end else if (32'(cfg_width) > MAX_WIDTH) begin
         last_col = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_BITS'(32'(cfg_width) - 1);
      end
      priority if (cfg_height == '0) begin
         last_row = '0;
      end else if (32'(cfg_height) > HEIGHT_LIMIT) begin
         last_row = ROW_BITS'(HEIGHT_LIMIT - 1);
      end else begin
         last_row = ROW_BITS'(32'(cfg_height) - 1);
      end
   end

   always_comb begin
      pos.col       = col_ff;
      pos.interior  = row_ff >= FIRST_INTERIOR_ROW;
      pos.row_end   = col_ff >= last_col;
      pos.frame_end = pos.row_end && (row_ff >= last_row);
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (pos.row_end) begin
            col_in = '0;
            row_in = pos.frame_end ? '0 : row_ff + ROW_BITS'(1);
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ design/vcd_checker.sv @@
// Port-level checker for the comb detector, bound to the top level.
// Depends on vcd_pkg and vertical_comb_detect_core_macros.svh.
`include "vertical_comb_detect_core_macros.svh"

module vcd_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_stall,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [vcd_pkg::PIX_BITS-1:0] rsp_comb_value,
   input  logic                         rsp_interior,
   input  logic                         rsp_row_end,
   input  logic                         rsp_frame_end
);
   import vcd_pkg::*;

   // stalled result keeps its payload
   `VCD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_comb_value) && $stable(rsp_interior) && $stable(rsp_row_end) && $stable(rsp_frame_end), "stalled result changed")

   // border results carry a zero metric
   `VCD_ASSERT(a_border_zero, clock, reset, rsp_valid && !rsp_interior |-> rsp_comb_value == '0, "border result with nonzero metric")

   `VCD_ASSERT(a_frame_row_end, clock, reset, rsp_valid && rsp_frame_end |-> rsp_row_end, "frame end without row end")

   // clearing pass blocks requests and no result exists right after reset
   `VCD_ASSERT_ALWAYS(a_reset_exit, clock, $past(reset) && !reset |-> req_stall && !rsp_valid, "request taken or result shown right after reset")

endmodule

bind vertical_comb_detect_core vcd_checker u_vcd_checker (.*);
